// ===== rtl/core/y2nv_pkg.sv =====
// Shared types and constants for the YUYV 4:2:2 to NV12 4:2:0 converter.
// Used by the converter top level and by its port checker.
`default_nettype none

package y2nv_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 22;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned S_DATA_W  = 16;
  localparam int unsigned M_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Register values after reset.
  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd1920;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd1536;

  // Destination plane of a result item.
  typedef enum logic [0:0] {
    PLANE_Y  = 1'b0,
    PLANE_UV = 1'b1
  } plane_e;

endpackage

`default_nettype wire

// ===== rtl/core/yuyv_to_nv12_converter.sv =====
// YUYV 4:2:2 pixel stream to NV12 4:2:0 byte-write stream converter.
// Depends on y2nv_pkg for field widths, register indexes and plane codes.
//
//   channel  | direction | carries
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | one pixel per item: luma, chroma, frame start flag
//   m_axis   | out       | one plane byte write per item, tlast ends a pixel
//   cfg      | in        | write-only image width and height registers
//
// A pixel can enter every cycle while the result register keeps up; it passes the
// input stage (line buffer read, counters) and then sits in the result register,
// so its first result is offered once it has passed both registers. The result
// register sends one item per cycle while m_axis_tready is high, so a pixel with a
// chroma result holds it for both its writes and the input stage stalls meanwhile.
// Reset clears the counters and stages; the line buffer is not cleared.
// A stall on m_axis backs up through both stages to s_axis_tready.
`default_nettype none

module yuyv_to_nv12_converter #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Pixel input.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [y2nv_pkg::S_DATA_W-1:0]    s_axis_tdata,  // luma[7:0], chroma[15:8]
  input  wire logic                             s_axis_tuser,  // frame_start
  // Byte writes out.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [y2nv_pkg::M_DATA_W-1:0]         m_axis_tdata,  // byte_address[21:0],
                                                               // byte_value[29:22], zeros
  output logic                                  m_axis_tuser,  // plane
  output logic                                  m_axis_tlast,  // last_of_item
  // Configuration writes.
  input  wire logic                             cfg_we_i,
  input  wire logic [y2nv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [y2nv_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCW = (WW > y2nv_pkg::CFG_W) ? WW : y2nv_pkg::CFG_W;
  localparam int unsigned HCW = (HW > y2nv_pkg::CFG_W) ? HW : y2nv_pkg::CFG_W;
  localparam int unsigned SW  = (RW + WW + 1 > y2nv_pkg::ADDR_W) ?
                                (RW + WW + 1) : y2nv_pkg::ADDR_W;
  localparam int unsigned PADW = y2nv_pkg::M_DATA_W - y2nv_pkg::ADDR_W - y2nv_pkg::BYTE_W;

  // Configuration registers.
  logic [y2nv_pkg::CFG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= y2nv_pkg::IMAGE_WIDTH_RST;
      height_q <= y2nv_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        y2nv_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        y2nv_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, anything above the maximum as the maximum.
  logic [WCW-1:0] width_ext;
  logic [HCW-1:0] height_ext;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;

  always_comb begin
    width_ext  = WCW'(width_q);
    height_ext = HCW'(height_q);
    if (width_ext == '0) begin
      w_eff = WW'(1);
    end else if (width_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = width_ext[WW-1:0];
    end
    if (height_ext == '0) begin
      h_eff = HW'(1);
    end else if (height_ext > HCW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = height_ext[HW-1:0];
    end
  end

  // Pipeline handshake.
  logic s1_valid_q, s2_valid_q, phase_q, s2_has_uv_q;
  logic m_fire, s2_last_take, s2_free, s1_adv, accept;

  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign s2_last_take  = m_fire && m_axis_tlast;
  assign s2_free       = !s2_valid_q || s2_last_take;
  assign s1_adv        = s1_valid_q && s2_free;
  assign s_axis_tready = !s1_valid_q || s2_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Position of the incoming pixel and what its chroma does.
  logic [CW-1:0] col_q, col_cur, col_d;
  logic [RW-1:0] row_q, row_cur, row_d;
  logic [y2nv_pkg::BYTE_W-1:0] in_luma, in_chroma;
  logic col_has_pair, last_row, has_uv, store_chroma;

  always_comb begin
    in_luma   = s_axis_tdata[y2nv_pkg::BYTE_W-1:0];
    in_chroma = s_axis_tdata[2*y2nv_pkg::BYTE_W-1:y2nv_pkg::BYTE_W];
    col_cur   = s_axis_tuser ? '0 : col_q;
    row_cur   = s_axis_tuser ? '0 : row_q;

    // A trailing odd column has no chroma partner.
    col_has_pair = WW'(col_cur) < {w_eff[WW-1:1], 1'b0};
    last_row     = (HW'(row_cur) + HW'(1)) >= h_eff;
    // On an even last row the chroma goes out unaveraged.
    has_uv       = col_has_pair && (row_cur[0] || last_row);
    store_chroma = col_has_pair && !row_cur[0] && !last_row;

    if ((WW'(col_cur) + WW'(1)) >= w_eff) begin
      col_d = '0;
      row_d = last_row ? '0 : RW'(HW'(row_cur) + HW'(1));
    end else begin
      col_d = CW'(WW'(col_cur) + WW'(1));
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Chroma line buffer, one byte per column, read data registered.
  logic [y2nv_pkg::BYTE_W-1:0] line_mem [MAX_WIDTH];
  logic [y2nv_pkg::BYTE_W-1:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && store_chroma) begin
      line_mem[col_cur] <= in_chroma;
    end
    if (accept) begin
      line_rd_q <= line_mem[col_cur];
    end
  end

  // Input stage.
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic [y2nv_pkg::BYTE_W-1:0] s1_luma_q, s1_chroma_q;
  logic s1_has_uv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= col_cur;
      s1_row_q    <= row_cur;
      s1_luma_q   <= in_luma;
      s1_chroma_q <= in_chroma;
      s1_has_uv_q <= has_uv;
    end
  end

  // Addresses and chroma value for the result register.
  logic [SW-1:0] y_sum, uv_sum;
  logic [y2nv_pkg::BYTE_W:0] avg_sum;
  logic [y2nv_pkg::BYTE_W-1:0] uv_val_d;

  always_comb begin
    y_sum   = SW'(s1_row_q) * SW'(w_eff) + SW'(s1_col_q);
    uv_sum  = SW'(s1_row_q >> 1) * SW'(w_eff) + SW'(s1_col_q);
    avg_sum = (y2nv_pkg::BYTE_W + 1)'(line_rd_q) + (y2nv_pkg::BYTE_W + 1)'(s1_chroma_q)
              + (y2nv_pkg::BYTE_W + 1)'(1);
    uv_val_d = s1_row_q[0] ? avg_sum[y2nv_pkg::BYTE_W:1] : s1_chroma_q;
  end

  // Result register holding both results of one pixel.
  logic [y2nv_pkg::ADDR_W-1:0] y_addr_q, uv_addr_q;
  logic [y2nv_pkg::BYTE_W-1:0] y_val_q, uv_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (s2_last_take) begin
        s2_valid_q <= 1'b0;
      end
      // The chroma result follows once the luma result is taken.
      if (s1_adv) begin
        phase_q <= 1'b0;
      end else if (m_fire && !m_axis_tlast) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      y_addr_q    <= y_sum[y2nv_pkg::ADDR_W-1:0];
      uv_addr_q   <= uv_sum[y2nv_pkg::ADDR_W-1:0];
      y_val_q     <= s1_luma_q;
      uv_val_q    <= uv_val_d;
      s2_has_uv_q <= s1_has_uv_q;
    end
  end

  y2nv_pkg::plane_e out_plane;

  always_comb begin
    out_plane     = phase_q ? y2nv_pkg::PLANE_UV : y2nv_pkg::PLANE_Y;
    m_axis_tvalid = s2_valid_q;
    m_axis_tuser  = out_plane;
    m_axis_tlast  = phase_q || !s2_has_uv_q;
    m_axis_tdata  = {PADW'(0),
                     phase_q ? uv_val_q : y_val_q,
                     phase_q ? uv_addr_q : y_addr_q};
  end

endmodule

`default_nettype wire

// ===== rtl/core/y2nv_checker.sv =====
// Port-level checker for the YUYV to NV12 converter, bound to its top level.
// Depends on y2nv_pkg for the plane codes and stream widths.
`default_nettype none

module y2nv_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [y2nv_pkg::M_DATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tuser,
  input wire logic                          m_axis_tlast
);

  // No result is offered in the cycle after reset is seen held.
  a_idle_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result offered during reset");

  // A stalled result keeps its contents.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Only a luma write can leave a pixel unfinished, and a chroma write ends it.
  a_first_is_luma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == y2nv_pkg::PLANE_Y)
    else $error("unfinished pixel on chroma plane");

  // The chroma write of a pixel follows right after its luma write.
  a_uv_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == y2nv_pkg::PLANE_UV && m_axis_tlast)
    else $error("chroma write missing after luma write");

endmodule

bind yuyv_to_nv12_converter y2nv_checker u_y2nv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
